[design/lru_stack_distance_profiler_core_macros.svh]
// assertion macros for the stack distance profiler
`ifndef LRU_STACK_DISTANCE_PROFILER_CORE_MACROS_SVH
`define LRU_STACK_DISTANCE_PROFILER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define LSDP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lsdp check failed");
`define LSDP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lsdp check failed");
`else
`define LSDP_ASSERT_SAME(lbl, ante, cons)
`define LSDP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[design/lsdp_pkg.sv]
// types and constants of the stack distance profiler
`default_nettype none
package lsdp_pkg;
    localparam int STACK_DEPTH = 8;
    localparam int CLASS_COUNT = 16;
    localparam int OWNER_COUNT = 16;
    localparam int RUN_COUNT   = 1024;
    localparam int ROW_COUNT   = OWNER_COUNT * CLASS_COUNT;
    localparam int ROW_W       = $clog2(ROW_COUNT);
    localparam int RUN_W       = $clog2(RUN_COUNT);
    localparam int POS_W       = $clog2(STACK_DEPTH + 1);

    localparam logic [1:0] OP_EMPTY    = 2'd0;
    localparam logic [1:0] OP_DECOMMIT = 2'd1;
    localparam logic [1:0] OP_ALLOC    = 2'd2;
    localparam logic [1:0] OP_INIT     = 2'd3;

    localparam logic [1:0] REASON_COLD = 2'd2;

    typedef struct packed {
        logic [1:0] opcode;
        logic [3:0] owner_slot;
        logic       owner_valid;
        logic [7:0] size_class;
        logic [9:0] run_id;
        logic [1:0] decommit_reason;
    } evt_t;

    typedef struct packed {
        logic        accepted;
        logic [3:0]  stack_distance;
        logic [2:0]  distance_bin;
        logic [3:0]  model_mask;
        logic [1:0]  reason_code;
        logic        ghost_reuse;
        logic [63:0] epoch_delta;
        logic [1:0]  epoch_bin;
    } res_t;

    typedef struct packed {
        logic       vld;
        logic [9:0] run;
    } stk_ent_t;

    typedef struct packed {
        stk_ent_t [STACK_DEPTH-1:0] ent;
        logic [63:0]                epoch;
    } stk_row_t;

    typedef struct packed {
        logic [3:0]  empty_dist;
        logic        ghost;
        logic [63:0] dc_epoch;
        logic [3:0]  dc_dist;
        logic [1:0]  dc_reason;
    } run_rec_t;

    typedef struct packed {
        logic     stk_we;
        stk_row_t stk_wdata;
        logic     run_we;
        run_rec_t run_wdata;
    } upd_t;

    localparam int STK_W = $bits(stk_row_t);
    localparam int RUN_REC_W = $bits(run_rec_t);
endpackage
`default_nettype wire

[design/lsdp_ram.sv]
// generic single-port-write ram with registered read
`default_nettype none
module lsdp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

[design/lsdp_eval.sv]
// event evaluation: stack search, move to front, per-run record update
`default_nettype none
module lsdp_eval (
    input  lsdp_pkg::evt_t     evt,
    input  wire logic          row_vld,
    input  lsdp_pkg::stk_row_t stk_rd,
    input  lsdp_pkg::run_rec_t run_rd,
    output lsdp_pkg::res_t     res,
    output lsdp_pkg::upd_t     upd
);
    import lsdp_pkg::*;

    stk_row_t          cur;
    stk_row_t          moved;
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  lim;
    logic [POS_W:0]    dfull;
    logic [3:0]        dsat;
    logic [3:0]        dc_d;
    logic              ok;
    logic [63:0]       delta;
    run_rec_t          rec;

    function automatic logic [2:0] bin_of(input logic [3:0] d);
        if (d >= 4'd1 && d <= 4'd4)
        begin
            return 3'(d - 4'd1);
        end
        return 3'd4;
    endfunction

    function automatic logic [3:0] mask_of(input logic [3:0] d);
        logic [3:0] m;
        m = '0;
        for (int k = 0; k < 4; k++)
        begin
            m[k] = (d > 4'(k + 1));
        end
        return m;
    endfunction

    always_comb
    begin
        cur = row_vld ? stk_rd : '0;
        pos = POS_W'(STACK_DEPTH);
        for (int i = STACK_DEPTH - 1; i >= 0; i--)
        begin
            if (cur.ent[i].vld && cur.ent[i].run == evt.run_id)
            begin
                pos = POS_W'(i);
            end
        end
        lim = (pos < POS_W'(STACK_DEPTH)) ? pos : POS_W'(STACK_DEPTH - 1);
        moved = cur;
        moved.epoch = cur.epoch + 64'd1;
        for (int i = 1; i < STACK_DEPTH; i++)
        begin
            if (POS_W'(i) <= lim)
            begin
                moved.ent[i] = cur.ent[i-1];
            end
        end
        moved.ent[0].vld = 1'b1;
        moved.ent[0].run = evt.run_id;
        dfull = (POS_W+1)'(pos) + (POS_W+1)'(1);
        dsat = (dfull > (POS_W+1)'(15)) ? 4'd15 : 4'(dfull);
        dc_d = (run_rd.empty_dist != 4'd0) ? run_rd.empty_dist : dsat;
        delta = (cur.epoch >= run_rd.dc_epoch) ? cur.epoch - run_rd.dc_epoch : 64'd0;
        ok = evt.owner_valid && (int'(evt.owner_slot) < OWNER_COUNT)
            && (int'(evt.size_class) < CLASS_COUNT) && (int'(evt.run_id) < RUN_COUNT);

        res = '0;
        upd = '0;
        upd.stk_wdata = moved;
        rec = run_rd;
        unique case (evt.opcode)
            OP_INIT:
            begin
                res.accepted = (int'(evt.owner_slot) < OWNER_COUNT);
            end
            OP_EMPTY:
            begin
                if (ok)
                begin
                    res.accepted = 1'b1;
                    res.stack_distance = dsat;
                    res.distance_bin = bin_of(dsat);
                    rec.empty_dist = dsat;
                    rec.ghost = 1'b0;
                    upd.stk_we = 1'b1;
                    upd.run_we = 1'b1;
                end
            end
            OP_DECOMMIT:
            begin
                if (ok)
                begin
                    res.accepted = 1'b1;
                    res.stack_distance = dc_d;
                    res.distance_bin = bin_of(dc_d);
                    res.model_mask = mask_of(dc_d);
                    res.reason_code = (evt.decommit_reason > REASON_COLD)
                        ? REASON_COLD : evt.decommit_reason;
                    rec.dc_epoch = cur.epoch;
                    rec.dc_dist = dc_d;
                    rec.dc_reason = res.reason_code;
                    rec.ghost = 1'b1;
                    upd.run_we = 1'b1;
                end
            end
            OP_ALLOC:
            begin
                if (ok)
                begin
                    res.accepted = 1'b1;
                    if (run_rd.ghost)
                    begin
                        res.stack_distance = run_rd.dc_dist;
                        res.distance_bin = bin_of(run_rd.dc_dist);
                        res.model_mask = mask_of(run_rd.dc_dist);
                        res.reason_code = (run_rd.dc_reason > REASON_COLD)
                            ? REASON_COLD : run_rd.dc_reason;
                        res.ghost_reuse = 1'b1;
                        res.epoch_delta = delta;
                        res.epoch_bin = (delta <= 64'd1) ? 2'd0 :
                                        (delta <= 64'd3) ? 2'd1 :
                                        (delta <= 64'd7) ? 2'd2 : 2'd3;
                        rec.ghost = 1'b0;
                        upd.run_we = 1'b1;
                    end
                end
            end
            default:
            begin
                res = '0;
            end
        endcase
        upd.run_wdata = rec;
    end
endmodule
`default_nettype wire

[design/lru_stack_distance_profiler_core.sv]
// top level of the lru stack distance profiler
//
// one event word in on evt, one result word out on res, both valid/stall
// handshakes; evt_stall high holds off the sender
// an accepted event reads its stack row and run record from two rams with
// registered read data, then the result is registered and the row and record
// written back in that same cycle, unless a held result stalls it; evt_stall
// stays high until that write-back, and the read-then-write of the stack row
// ram sets the rate
// a result held by res_stall lets one more event in, which then waits in its
// write-back cycle with evt_stall high until the held word is taken
// after reset the per-run record ram is swept to zero, one entry a cycle,
// all 1024 entries, during which evt_stall stays high
// stack rows carry a valid flop each, so owner init clears all of its rows at once
`default_nettype none
`include "lru_stack_distance_profiler_core_macros.svh"
module lru_stack_distance_profiler_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           evt_valid,
    output logic                evt_stall,
    input  lsdp_pkg::evt_t      evt,
    output logic                res_valid,
    input  wire logic           res_stall,
    output lsdp_pkg::res_t      res
);
    import lsdp_pkg::*;

    typedef enum logic [2:0] {
        ST_CLR  = 3'b001,
        ST_IDLE = 3'b010,
        ST_BUSY = 3'b100
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic [RUN_W-1:0]       clr_cnt_reg;
    logic [ROW_COUNT-1:0]   row_vld_reg;
    evt_t                   evt_reg;
    res_t                   res_reg;
    logic                   res_valid_reg;

    logic                   in_acc;
    logic                   fire;
    logic [ROW_W-1:0]       rd_row;
    logic [ROW_W-1:0]       cur_row;
    logic [STK_W-1:0]       stk_rdata;
    logic [RUN_REC_W-1:0]   run_rdata;
    logic                   run_we;
    logic [RUN_W-1:0]       run_waddr;
    logic [RUN_REC_W-1:0]   run_wdata;
    res_t                   eval_res;
    upd_t                   upd;

    assign in_acc    = evt_valid && (state_reg == ST_IDLE);
    assign evt_stall = (state_reg != ST_IDLE);
    assign fire      = (state_reg == ST_BUSY) && (!res_valid_reg || !res_stall);
    assign rd_row    = ROW_W'(ROW_W'(evt.owner_slot) * ROW_W'(CLASS_COUNT)
                       + ROW_W'(evt.size_class));
    assign cur_row   = ROW_W'(ROW_W'(evt_reg.owner_slot) * ROW_W'(CLASS_COUNT)
                       + ROW_W'(evt_reg.size_class));

    assign run_we    = (state_reg == ST_CLR) || (fire && upd.run_we);
    assign run_waddr = (state_reg == ST_CLR) ? clr_cnt_reg : evt_reg.run_id[RUN_W-1:0];
    assign run_wdata = (state_reg == ST_CLR) ? '0 : upd.run_wdata;

    lsdp_ram #(.WIDTH(STK_W), .DEPTH(ROW_COUNT)) u_stk_ram (
        .clk   (clk),
        .we    (fire && upd.stk_we),
        .waddr (cur_row),
        .wdata (upd.stk_wdata),
        .re    (in_acc),
        .raddr (rd_row),
        .rdata (stk_rdata)
    );

    lsdp_ram #(.WIDTH(RUN_REC_W), .DEPTH(RUN_COUNT)) u_run_ram (
        .clk   (clk),
        .we    (run_we),
        .waddr (run_waddr),
        .wdata (run_wdata),
        .re    (in_acc),
        .raddr (evt.run_id[RUN_W-1:0]),
        .rdata (run_rdata)
    );

    lsdp_eval u_eval (
        .evt     (evt_reg),
        .row_vld (row_vld_reg[cur_row]),
        .stk_rd  (stk_rdata),
        .run_rd  (run_rdata),
        .res     (eval_res),
        .upd     (upd)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLR:
            begin
                if (clr_cnt_reg == RUN_W'(RUN_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY:
            begin
                if (fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            clr_cnt_reg   <= '0;
            row_vld_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLR)
            begin
                clr_cnt_reg <= clr_cnt_reg + RUN_W'(1);
            end
            if (fire)
            begin
                res_valid_reg <= 1'b1;
                if (upd.stk_we)
                begin
                    row_vld_reg[cur_row] <= 1'b1;
                end
                if (evt_reg.opcode == OP_INIT && eval_res.accepted)
                begin
                    for (int i = 0; i < ROW_COUNT; i++)
                    begin
                        if (i / CLASS_COUNT == int'(evt_reg.owner_slot))
                        begin
                            row_vld_reg[i] <= 1'b0;
                        end
                    end
                end
            end
            else if (res_valid_reg && !res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            evt_reg <= evt;
        end
        if (fire)
        begin
            res_reg <= eval_res;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    `LSDP_ASSERT_NEXT(a_acc_busy, in_acc, state_reg == ST_BUSY)
    `LSDP_ASSERT_SAME(a_clr_stall, state_reg == ST_CLR, evt_stall && !run_we == 1'b0)
    `LSDP_ASSERT_SAME(a_res_src, $rose(res_valid_reg), $past(state_reg) == ST_BUSY)
    `LSDP_ASSERT_SAME(a_no_wr_idle, state_reg == ST_IDLE, !run_we)
endmodule
`default_nettype wire
